// ===== src/cscd_pkg.sv =====
// Package of the C source delimiter checker: constants, state type and helper functions.
`default_nettype none
package cscd_pkg;

   localparam int BalanceBits = 16;
   localparam int ReportBits  = 16;
   localparam int WideBits    = (BalanceBits > ReportBits) ? BalanceBits : ReportBits;

   localparam logic [7:0] CharNewline = 8'h0A;
   localparam logic [7:0] CharStar    = 8'h2A;
   localparam logic [7:0] CharSlash   = 8'h2F;
   localparam logic [7:0] CharDquote  = 8'h22;
   localparam logic [7:0] CharSquote  = 8'h27;
   localparam logic [7:0] CharLparen  = 8'h28;
   localparam logic [7:0] CharRparen  = 8'h29;
   localparam logic [7:0] CharLbrack  = 8'h5B;
   localparam logic [7:0] CharRbrack  = 8'h5D;
   localparam logic [7:0] CharLbrace  = 8'h7B;
   localparam logic [7:0] CharRbrace  = 8'h7D;

   typedef logic signed [BalanceBits-1:0] balance_type;
   typedef logic signed [ReportBits-1:0]  report_type;

   typedef struct packed {
      balance_type paren;
      balance_type bracket;
      balance_type brace;
      logic        squote;
      logic        dquote;
      logic        in_line;
      logic        in_block;
      logic        in_string;
      logic        overflow;
   } scan_state_type;

   localparam scan_state_type ScanStateReset = '{
      paren: '0, bracket: '0, brace: '0, squote: 1'b0, dquote: 1'b0,
      in_line: 1'b0, in_block: 1'b0, in_string: 1'b0, overflow: 1'b0};

   typedef struct packed {
      logic       syntax_ok;
      report_type paren;
      report_type bracket;
      report_type brace;
      logic       squote_odd;
      logic       dquote_odd;
      logic       overflow;
   } verdict_type;

   // Adds +1 or -1; the top bit of the result flags a step out of range, in which
   // case the value is returned unchanged.
   function automatic logic [BalanceBits:0] bump(input balance_type v, input logic up);
      logic [BalanceBits:0] sum;
      logic [BalanceBits:0] delta;
      delta = up ? {{BalanceBits{1'b0}}, 1'b1} : {(BalanceBits+1){1'b1}};
      sum   = {v[BalanceBits-1], v} + delta;
      if (sum[BalanceBits] != sum[BalanceBits-1]) begin
         return {1'b1, v};
      end
      return {1'b0, sum[BalanceBits-1:0]};
   endfunction

   // Saturates a balance into the reported width.
   function automatic report_type report(input balance_type v);
      logic signed [WideBits-1:0] w;
      logic signed [WideBits-1:0] hi;
      logic signed [WideBits-1:0] lo;
      w  = WideBits'(v);
      hi = WideBits'($signed({1'b0, {(ReportBits-1){1'b1}}}));
      lo = WideBits'($signed({1'b1, {(ReportBits-1){1'b0}}}));
      if (w > hi) begin
         w = hi;
      end
      if (w < lo) begin
         w = lo;
      end
      return w[ReportBits-1:0];
   endfunction

endpackage
`default_nettype wire

// ===== src/cscd_step.sv =====
// One classification and update step for a single source byte and its lookahead.
`default_nettype none
module cscd_step (
   input  wire cscd_pkg::scan_state_type state_in,
   input  wire logic [7:0]               char_in,
   input  wire logic [7:0]               next_char,
   input  wire logic                     next_present,
   output cscd_pkg::scan_state_type      state_out
);
   import cscd_pkg::*;

   logic                 next_slash;
   logic                 next_star;
   logic [BalanceBits:0] bumped;

   assign next_slash = next_present && (next_char == CharSlash);
   assign next_star  = next_present && (next_char == CharStar);

   always_comb begin
      state_out = state_in;
      bumped    = '0;
      if (state_in.in_line && char_in == CharNewline) begin
         state_out.in_line = 1'b0;
      end else if (state_in.in_block && char_in == CharStar && next_slash) begin
         state_out.in_block = 1'b0;
      end else if (char_in == CharSlash && next_slash && !state_in.in_line &&
                   !state_in.in_string) begin
         state_out.in_line = 1'b1;
      end else if (char_in == CharSlash && next_star && !state_in.in_block &&
                   !state_in.in_string) begin
         state_out.in_block = 1'b1;
      end else if (char_in == CharDquote && !state_in.in_line && !state_in.in_block) begin
         state_out.in_string = !state_in.in_string;
         state_out.dquote    = !state_in.dquote;
      end else if (state_in.in_line || state_in.in_block || state_in.in_string) begin
         state_out = state_in;
      end else begin
         case (char_in) inside
            CharLparen, CharRparen: begin
               bumped = bump(state_in.paren, char_in == CharLparen);
               state_out.paren = bumped[BalanceBits-1:0];
            end
            CharLbrack, CharRbrack: begin
               bumped = bump(state_in.bracket, char_in == CharLbrack);
               state_out.bracket = bumped[BalanceBits-1:0];
            end
            CharLbrace, CharRbrace: begin
               bumped = bump(state_in.brace, char_in == CharLbrace);
               state_out.brace = bumped[BalanceBits-1:0];
            end
            CharSquote: state_out.squote = !state_in.squote;
            default:    state_out = state_in;
         endcase
         state_out.overflow = state_in.overflow | bumped[BalanceBits];
      end
   end

endmodule
`default_nettype wire

// ===== src/cscd_tracker.sv =====
// Scan state registers, held lookahead byte and verdict formation.
`default_nettype none
module cscd_tracker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              beat_fire,
   input  wire logic [7:0]        beat_char,
   input  wire logic              beat_last,
   output cscd_pkg::verdict_type  verdict
);
   import cscd_pkg::*;

   scan_state_type state_ff, state_in;
   scan_state_type held_done;
   scan_state_type last_done;
   scan_state_type after_held;
   logic [7:0]     held_char_ff, held_char_in;
   logic           held_valid_ff, held_valid_in;

   // Completes the held byte, using the arriving byte as its lookahead.
   cscd_step u_step_held (
      .state_in     (state_ff),
      .char_in      (held_char_ff),
      .next_char    (beat_char),
      .next_present (1'b1),
      .state_out    (held_done)
   );

   assign after_held = held_valid_ff ? held_done : state_ff;

   // Completes the final byte, which has no lookahead.
   cscd_step u_step_last (
      .state_in     (after_held),
      .char_in      (beat_char),
      .next_char    (beat_char),
      .next_present (1'b0),
      .state_out    (last_done)
   );

   always_comb begin
      state_in      = state_ff;
      held_char_in  = held_char_ff;
      held_valid_in = held_valid_ff;
      if (beat_fire) begin
         if (beat_last) begin
            state_in      = ScanStateReset;
            held_valid_in = 1'b0;
         end else begin
            state_in      = after_held;
            held_char_in  = beat_char;
            held_valid_in = 1'b1;
         end
      end
   end

   always_comb begin
      verdict.paren      = report(last_done.paren);
      verdict.bracket    = report(last_done.bracket);
      verdict.brace      = report(last_done.brace);
      verdict.squote_odd = last_done.squote;
      verdict.dquote_odd = last_done.dquote;
      verdict.overflow   = last_done.overflow;
      verdict.syntax_ok  = (last_done.paren == '0) && (last_done.bracket == '0) &&
                           (last_done.brace == '0) && !last_done.squote &&
                           !last_done.dquote && !last_done.overflow;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ScanStateReset;
         held_char_ff  <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         held_char_ff  <= held_char_in;
         held_valid_ff <= held_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/c_source_delimiter_checker_unit.sv =====
// Top level of the C source delimiter checker: input register, tracker and result register.
`default_nettype none
// The unit reads C source text one byte per beat on the req_ channel and, on the beat
// marked end_of_text, returns one verdict beat on the rsp_ channel. It tracks line
// comments, block comments and strings; outside them it keeps signed 16-bit balances
// of parentheses, brackets and braces and a parity of single quotes, and it keeps a
// parity of double quotes seen outside comments. A balance step that would leave the
// signed range is dropped and sets a sticky overflow flag, which fails the verdict.
// Escape sequences get no special handling. Each byte is decided only when the next
// byte arrives, since a slash or star needs its follower; the final byte is decided
// with no follower. After the verdict all scan state returns to its reset value, so
// the next byte starts a fresh text. The unit takes one byte every cycle while no final
// byte waits: a byte is captured in an input register, and when it leaves that register
// the compare and increment logic completes the held byte with it as lookahead and holds
// it in turn; a final byte is also completed there, by a second step in series, and
// its verdict loads the result register, from which the verdict beat is offered. Input
// bytes keep flowing while a verdict waits to be taken; only a second final byte stalls
// until the result register is free.
module c_source_delimiter_checker_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_text_byte,
   input  wire logic        req_end_of_text,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_syntax_ok,
   output logic signed [15:0] rsp_paren_balance,
   output logic signed [15:0] rsp_bracket_balance,
   output logic signed [15:0] rsp_brace_balance,
   output logic             rsp_single_quote_odd,
   output logic             rsp_double_quote_odd,
   output logic             rsp_count_overflow
);
   import cscd_pkg::*;

   // Input register stage.
   logic        stage_valid_ff, stage_valid_in;
   logic [7:0]  stage_char_ff, stage_char_in;
   logic        stage_last_ff, stage_last_in;
   logic        stage_fire;
   logic        result_free;
   logic        req_fire;

   // Result register.
   logic        result_valid_ff, result_valid_in;
   verdict_type result_ff, result_in;
   verdict_type verdict;

   // The result register is free when empty or when its beat leaves this cycle.
   assign result_free = !result_valid_ff || rsp_ready;

   // A byte that is not final never needs the result register.
   assign stage_fire = stage_valid_ff && (!stage_last_ff || result_free);
   assign req_ready  = !stage_valid_ff || stage_fire;
   assign req_fire   = req_valid && req_ready;

   always_comb begin
      stage_valid_in = stage_valid_ff;
      stage_char_in  = stage_char_ff;
      stage_last_in  = stage_last_ff;
      if (req_fire) begin
         stage_valid_in = 1'b1;
         stage_char_in  = req_text_byte;
         stage_last_in  = req_end_of_text;
      end else if (stage_fire) begin
         stage_valid_in = 1'b0;
      end
   end

   cscd_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .beat_fire (stage_fire),
      .beat_char (stage_char_ff),
      .beat_last (stage_last_ff),
      .verdict   (verdict)
   );

   always_comb begin
      result_valid_in = result_valid_ff;
      result_in       = result_ff;
      if (stage_fire && stage_last_ff) begin
         result_valid_in = 1'b1;
         result_in       = verdict;
      end else if (rsp_ready) begin
         result_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff  <= stage_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      stage_char_ff <= stage_char_in;
      stage_last_ff <= stage_last_in;
      result_ff     <= result_in;
   end

   assign rsp_valid            = result_valid_ff;
   assign rsp_syntax_ok        = result_ff.syntax_ok;
   assign rsp_paren_balance    = result_ff.paren;
   assign rsp_bracket_balance  = result_ff.bracket;
   assign rsp_brace_balance    = result_ff.brace;
   assign rsp_single_quote_odd = result_ff.squote_odd;
   assign rsp_double_quote_odd = result_ff.dquote_odd;
   assign rsp_count_overflow   = result_ff.overflow;

`ifndef ASSERT_OFF
   // A final byte is only processed when the result register can take its verdict.
   assert property (@(posedge clock) disable iff (reset)
      stage_fire && stage_last_ff |-> !result_valid_ff || rsp_ready)
      else $error("final byte processed while result register busy");

   // Every processed final byte shows up as a verdict beat in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      stage_fire && stage_last_ff |=> rsp_valid)
      else $error("verdict not presented after final byte");

   // The verdict agrees with the reported balances, parities and overflow flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_syntax_ok == ((rsp_paren_balance == 16'sd0) &&
         (rsp_bracket_balance == 16'sd0) && (rsp_brace_balance == 16'sd0) &&
         !rsp_single_quote_odd && !rsp_double_quote_odd && !rsp_count_overflow))
      else $error("verdict inconsistent with reported counts");
`endif

endmodule
`default_nettype wire

// ===== dv/c_source_delimiter_checker_unit_test.sv =====
// Self-checking testbench of the C source delimiter checker unit.
`timescale 1ns / 100ps

module c_source_delimiter_checker_unit_test;
   import cscd_pkg::*;

   // Printable characters used to build plausible source text.
   localparam logic [7:0] CharSpace  = 8'h20;
   localparam logic [7:0] CharLowerA = 8'h61;

   // The lookahead seen by the final byte of a text matches no character at all.
   localparam logic [8:0] NoLookahead = 9'h100;

   localparam longint BalanceMax = (longint'(1) <<< (BalanceBits - 1)) - 1;
   localparam longint BalanceMin = -BalanceMax - 1;
   localparam longint ReportMax  = (longint'(1) <<< (ReportBits - 1)) - 1;
   localparam longint ReportMin  = -ReportMax - 1;

   // Idle mixes of the three phases, in percent per cycle.
   localparam int SendIdlePct [3] = '{29, 70, 0};
   localparam int RecvIdlePct [3] = '{70, 29, 0};

   localparam int RandomBytesPerPhase = 350;
   localparam int PressureTexts       = 30;
   localparam int HoldOffCycles       = 400;
   localparam int QuietLimit          = 4000;
   localparam int DrainCycles         = 10;

   // Predicts each verdict from the accepted text bytes and holds the verdicts that
   // are still to come out of the unit.
   class verdict_scoreboard;
      logic [7:0]  held_char;
      bit          held_valid;
      balance_type paren;
      balance_type bracket;
      balance_type brace;
      bit          squote;
      bit          dquote;
      bit          in_line;
      bit          in_block;
      bit          in_string;
      bit          overflow;
      verdict_type expected_verdicts[$];
      int          errors;
      int          bytes_noted;
      int          verdicts_checked;

      function new();
         errors = 0;
         bytes_noted = 0;
         verdicts_checked = 0;
         clear_scan();
      endfunction

      function void clear_scan();
         held_char = '0;
         held_valid = 1'b0;
         paren = '0;
         bracket = '0;
         brace = '0;
         squote = 1'b0;
         dquote = 1'b0;
         in_line = 1'b0;
         in_block = 1'b0;
         in_string = 1'b0;
         overflow = 1'b0;
      endfunction

      function balance_type step_balance(balance_type v, int delta);
         longint n;
         n = longint'(v) + delta;
         if (n > BalanceMax || n < BalanceMin) begin
            overflow = 1'b1;
            return v;
         end
         return balance_type'(n);
      endfunction

      function report_type clamp_report(balance_type v);
         longint w;
         w = longint'(v);
         if (w > ReportMax) begin
            w = ReportMax;
         end
         if (w < ReportMin) begin
            w = ReportMin;
         end
         return report_type'(w);
      endfunction

      // Decides one character, given the character that follows it.
      function void scan_char(logic [7:0] ch, logic [8:0] next);
         if (in_line && ch == CharNewline) begin
            in_line = 1'b0;
         end else if (in_block && ch == CharStar && next == {1'b0, CharSlash}) begin
            in_block = 1'b0;
         end else if (ch == CharSlash && next == {1'b0, CharSlash} && !in_line && !in_string) begin
            in_line = 1'b1;
         end else if (ch == CharSlash && next == {1'b0, CharStar} && !in_block && !in_string) begin
            in_block = 1'b1;
         end else if (ch == CharDquote && !in_line && !in_block) begin
            in_string = !in_string;
            dquote = !dquote;
         end else if (!(in_line || in_block || in_string)) begin
            case (ch)
               CharLparen: paren = step_balance(paren, 1);
               CharRparen: paren = step_balance(paren, -1);
               CharLbrack: bracket = step_balance(bracket, 1);
               CharRbrack: bracket = step_balance(bracket, -1);
               CharLbrace: brace = step_balance(brace, 1);
               CharRbrace: brace = step_balance(brace, -1);
               CharSquote: squote = !squote;
               default: ;
            endcase
         end
      endfunction

      function void note_text_byte(logic [7:0] ch, logic last);
         verdict_type v;
         bytes_noted++;
         if (held_valid) begin
            scan_char(held_char, {1'b0, ch});
         end
         if (!last) begin
            held_char = ch;
            held_valid = 1'b1;
         end else begin
            scan_char(ch, NoLookahead);
            v.syntax_ok  = paren == 0 && bracket == 0 && brace == 0 &&
                           !squote && !dquote && !overflow;
            v.paren      = clamp_report(paren);
            v.bracket    = clamp_report(bracket);
            v.brace      = clamp_report(brace);
            v.squote_odd = squote;
            v.dquote_odd = dquote;
            v.overflow   = overflow;
            expected_verdicts.push_back(v);
            clear_scan();
         end
      endfunction

      function void compare_field(string field, longint want, longint seen);
         if (want != seen) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
         end
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (expected_verdicts.size() == 0) begin
            errors++;
            $display("%0t: verdict with none expected, expected nothing, actual ok=%0d paren=%0d",
                     $time, got.syntax_ok, $signed(got.paren));
            return;
         end
         want = expected_verdicts.pop_front();
         verdicts_checked++;
         compare_field("syntax_ok", want.syntax_ok, got.syntax_ok);
         compare_field("paren_balance", $signed(want.paren), $signed(got.paren));
         compare_field("bracket_balance", $signed(want.bracket), $signed(got.bracket));
         compare_field("brace_balance", $signed(want.brace), $signed(got.brace));
         compare_field("single_quote_odd", want.squote_odd, got.squote_odd);
         compare_field("double_quote_odd", want.dquote_odd, got.dquote_odd);
         compare_field("count_overflow", want.overflow, got.overflow);
      endfunction
   endclass

   // Every input of the unit starts at a known value; reset is held from time zero.
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_text_byte = '0;
   logic        req_end_of_text = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_syntax_ok;
   logic signed [15:0] rsp_paren_balance;
   logic signed [15:0] rsp_bracket_balance;
   logic signed [15:0] rsp_brace_balance;
   logic        rsp_single_quote_odd;
   logic        rsp_double_quote_odd;
   logic        rsp_count_overflow;

   verdict_scoreboard sb;
   verdict_type       observed_verdict;
   logic [7:0]        text_bytes[$];
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                hold_off_requests = 0;
   int                hold_off_served = 0;
   int                quiet_cycles = 0;

   c_source_delimiter_checker_unit DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_text_byte        (req_text_byte),
      .req_end_of_text      (req_end_of_text),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_syntax_ok        (rsp_syntax_ok),
      .rsp_paren_balance    (rsp_paren_balance),
      .rsp_bracket_balance  (rsp_bracket_balance),
      .rsp_brace_balance    (rsp_brace_balance),
      .rsp_single_quote_odd (rsp_single_quote_odd),
      .rsp_double_quote_odd (rsp_double_quote_odd),
      .rsp_count_overflow   (rsp_count_overflow)
   );

   always #1 clock = ~clock;

   // The monitor samples both channels at the rising edge. All stimulus changes by
   // nonblocking assignment, so the values read here are the ones the unit saw at
   // this edge. A verdict is taken only after its final byte has passed the input and
   // result registers, so noting the input before checking the output here is safe.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_text_byte(req_text_byte, req_end_of_text);
         end
         if (rsp_valid && rsp_ready) begin
            observed_verdict.syntax_ok  = rsp_syntax_ok;
            observed_verdict.paren      = rsp_paren_balance;
            observed_verdict.bracket    = rsp_bracket_balance;
            observed_verdict.brace      = rsp_brace_balance;
            observed_verdict.squote_odd = rsp_single_quote_odd;
            observed_verdict.dquote_odd = rsp_double_quote_odd;
            observed_verdict.overflow   = rsp_count_overflow;
            sb.check_verdict(observed_verdict);
         end
      end
   end

   // The watchdog ends the run when no beat moves on either channel for too long.
   // The longest legal quiet stretch is the deliberate receiver hold-off.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QuietLimit) begin
         $display("%0t: no beat accepted for %0d cycles", $time, QuietLimit);
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // The receiver stalls at random by the current idle mix. When the main process
   // asks for a hold-off, it keeps ready low for a long stretch that it counts itself,
   // so the unit fills up and has to stall its input.
   initial begin : receiver
      forever begin
         @(posedge clock);
         if (hold_off_requests != hold_off_served) begin
            hold_off_served = hold_off_served + 1;
            rsp_ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Offers one beat, idling first by the current mix, and returns in the time step
   // of its acceptance. Valid stays high from one beat to the next unless an idle
   // gap is chosen.
   task automatic send_beat(input logic [7:0] b, input logic last);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid       <= 1'b1;
      req_text_byte   <= b;
      req_end_of_text <= last;
      do @(posedge clock); while (!(req_valid && req_ready));
   endtask

   task automatic send_text();
      for (int i = 0; i < text_bytes.size(); i++) begin
         send_beat(text_bytes[i], i == text_bytes.size() - 1);
      end
   endtask

   task automatic load_text(input string s);
      text_bytes.delete();
      for (int i = 0; i < s.len(); i++) begin
         text_bytes.push_back(s[i]);
      end
   endtask

   function automatic logic [7:0] pick_delimiter();
      case ($urandom_range(5))
         0: return CharLparen;
         1: return CharRparen;
         2: return CharLbrack;
         3: return CharRbrack;
         4: return CharLbrace;
         default: return CharRbrace;
      endcase
   endfunction

   function automatic logic [7:0] pick_letter();
      return CharLowerA + 8'($urandom_range(25));
   endfunction

   // Content of comments, strings and noise: mostly characters that matter to the
   // scanner, some letters and some arbitrary bytes.
   function automatic logic [7:0] filler_char();
      case ($urandom_range(9))
         0: return CharSlash;
         1: return CharStar;
         2: return CharDquote;
         3: return CharSquote;
         4: return CharNewline;
         5: return pick_delimiter();
         6: return CharSpace;
         7: return 8'($urandom_range(255));
         default: return pick_letter();
      endcase
   endfunction

   task automatic push_filler(input logic [7:0] excluded);
      logic [7:0] c;
      repeat ($urandom_range(0, 5)) begin
         c = filler_char();
         text_bytes.push_back((c == excluded) ? CharSpace : c);
      end
   endtask

   // Builds one text from a few tokens. A tidy text nests its brackets properly and
   // closes every comment, string and character literal; its content is random.
   // An untidy text adds arbitrary bytes, stray characters and unterminated openers.
   task automatic compose_text(input bit tidy);
      logic [7:0] closers[$];
      text_bytes.delete();
      repeat ($urandom_range(1, 8)) begin
         case ($urandom_range(tidy ? 7 : 10))
            0: begin
               case ($urandom_range(2))
                  0: begin
                     text_bytes.push_back(CharLparen);
                     closers.push_back(CharRparen);
                  end
                  1: begin
                     text_bytes.push_back(CharLbrack);
                     closers.push_back(CharRbrack);
                  end
                  default: begin
                     text_bytes.push_back(CharLbrace);
                     closers.push_back(CharRbrace);
                  end
               endcase
            end
            1: begin
               if (closers.size() != 0) begin
                  text_bytes.push_back(closers.pop_back());
               end else begin
                  text_bytes.push_back(pick_letter());
               end
            end
            2: begin
               repeat ($urandom_range(1, 4)) text_bytes.push_back(pick_letter());
            end
            3: begin
               text_bytes.push_back(CharSlash);
               text_bytes.push_back(CharSlash);
               push_filler(CharNewline);
               text_bytes.push_back(CharNewline);
            end
            4: begin
               text_bytes.push_back(CharSlash);
               text_bytes.push_back(CharStar);
               push_filler(CharSlash);
               text_bytes.push_back(CharStar);
               text_bytes.push_back(CharSlash);
            end
            5: begin
               text_bytes.push_back(CharDquote);
               push_filler(CharDquote);
               text_bytes.push_back(CharDquote);
            end
            6: begin
               text_bytes.push_back(CharSquote);
               text_bytes.push_back($urandom_range(1) ? pick_letter() : pick_delimiter());
               text_bytes.push_back(CharSquote);
            end
            7: text_bytes.push_back($urandom_range(1) ? CharSpace : CharNewline);
            8: begin
               repeat ($urandom_range(1, 3)) text_bytes.push_back(8'($urandom_range(255)));
            end
            9: text_bytes.push_back(filler_char());
            default: begin
               case ($urandom_range(2))
                  0: text_bytes.push_back(CharDquote);
                  1: begin
                     text_bytes.push_back(CharSlash);
                     text_bytes.push_back(CharStar);
                  end
                  default: begin
                     text_bytes.push_back(CharSlash);
                     text_bytes.push_back(CharSlash);
                  end
               endcase
            end
         endcase
      end
      if (tidy || $urandom_range(1)) begin
         while (closers.size() != 0) text_bytes.push_back(closers.pop_back());
      end
      if (text_bytes.size() == 0) begin
         text_bytes.push_back(pick_letter());
      end
   endtask

   // Short directed texts: a lone slash whose lookahead lies past the end, every
   // bracket in both directions, a line comment opened inside a block comment that
   // outlives it, a backslash before a quote that escapes nothing, the lowest and
   // highest byte values with an odd single quote, and a double quote inside a
   // line comment that must not count.
   task automatic run_directed_texts();
      load_text("/");
      send_text();
      load_text("([{");
      send_text();
      load_text("}])");
      send_text();
      load_text("/*//*/(");
      send_text();
      load_text("\"\\\"");
      send_text();
      text_bytes = '{8'hFF, 8'h00, CharSquote};
      send_text();
      load_text("//\"\n\"");
      send_text();
   endtask

   // Main sequence: reset once, then three phases with different idle mixes. The
   // first phase opens with the directed texts; the last one holds off the receiver
   // while short texts keep coming.
   initial begin : stimulus
      int phase_bytes;
      sb = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      for (int phase = 0; phase < 3; phase++) begin
         send_idle_pct = SendIdlePct[phase];
         recv_idle_pct = RecvIdlePct[phase];
         if (phase == 0) begin
            run_directed_texts();
         end
         if (phase == 2) begin
            hold_off_requests = hold_off_requests + 1;
            repeat (PressureTexts) begin
               compose_text(1'b1);
               send_text();
            end
         end
         phase_bytes = 0;
         while (phase_bytes < RandomBytesPerPhase) begin
            compose_text($urandom_range(3) != 0);
            send_text();
            phase_bytes += text_bytes.size();
         end
      end
      // Lowered in the step of the last acceptance, so the final beat is not repeated.
      req_valid <= 1'b0;
      while (sb.expected_verdicts.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      $display("Checked %0d verdicts over %0d text bytes in three idle mixes,",
               sb.verdicts_checked, sb.bytes_noted);
      $display("with a long receiver hold-off that backed up the input.");
      if (sb.errors == 0 && sb.expected_verdicts.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
src/cscd_pkg.sv
src/cscd_step.sv
src/cscd_tracker.sv
src/c_source_delimiter_checker_unit.sv
dv/c_source_delimiter_checker_unit_test.sv
